### hdl/sbag_pkg.sv
// shared constants, register indexes and the bit gather function
`timescale 1ns / 1ps

package sbag_pkg;

   // fixed field widths
   localparam int FUNC_W      = 1;
   localparam int MEGA_POS_W  = 12;
   localparam int INNER_W     = 6;
   localparam int ADDR_W      = 40;
   localparam int SEL_W       = 60;
   localparam int SEL_FIELD_W = 5;
   localparam int SEL_FIELDS  = 12;
   localparam int SEL_RANGE   = 32;
   localparam int MEGA_DIM_W  = 7;
   localparam int STRIDE_W    = 11;
   localparam int LINE_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SEL_W;

   // parameter defaults
   localparam int OFFSET_BITS_DEF  = 12;
   localparam int MAX_MEGA_DIM_DEF = 64;

   // register reset values
   localparam logic [MEGA_DIM_W-1:0] MEGA_DIM_RST = MEGA_DIM_W'(1);
   localparam logic [STRIDE_W-1:0]   STRIDE_RST   = STRIDE_W'(8);
   localparam logic [LINE_W-1:0]     LINE_RST     = LINE_W'(1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SEL       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SEL       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEGA_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEGA_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_STR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_STR    = 3'd5;

   localparam logic FUNC_LIN_TO_BLK = 1'b0;

   // offset bit i takes val bit sel[i]; selectors past the inner width read zero
   function automatic logic [SEL_FIELDS-1:0] gather_bits(
      input logic [SEL_W-1:0]   sel_reg,
      input logic [INNER_W-1:0] val
   );
      logic [SEL_FIELDS-1:0] acc;
      logic [SEL_RANGE-1:0]  ext;
      ext = SEL_RANGE'(val);
      for (int i = 0; i < SEL_FIELDS; i++) begin
         acc[i] = ext[sel_reg[i*SEL_FIELD_W +: SEL_FIELD_W]];
      end
      return acc;
   endfunction

endpackage

### hdl/sbag_req_if.sv
// request channel: one micro block per transaction
`timescale 1ns / 1ps

interface sbag_req_if import sbag_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [MEGA_POS_W-1:0] mega_col;
   logic [MEGA_POS_W-1:0] mega_row;
   logic [INNER_W-1:0]    inner_x;
   logic [INNER_W-1:0]    inner_y;

   modport source (output valid, func, mega_col, mega_row, inner_x, inner_y,
                   input ready);
   modport sink   (input valid, func, mega_col, mega_row, inner_x, inner_y,
                   output ready);
endinterface

### hdl/sbag_rsp_if.sv
// response channel: copy offsets and flags per transaction
`timescale 1ns / 1ps

interface sbag_rsp_if import sbag_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] src_addr;
   logic [ADDR_W-1:0] dst_addr;
   logic              bypass;
   logic              stride_error;

   modport source (output valid, src_addr, dst_addr, bypass, stride_error,
                   input ready);
   modport sink   (input valid, src_addr, dst_addr, bypass, stride_error,
                   output ready);
endinterface

### hdl/swizzled_block_address_generator_unit.sv
// swizzled block address generator: five stage pipeline from request to response
// each request passes through stages one to five in order; response valid is the stage five valid bit
// throughput: one transaction per cycle while rsp ready; each full stage holds when the next stalls
// the divider for tile column and row spans stages two and three, the multipliers stages two to four
// reset (synchronous) clears all stage valid bits and returns the registers to their defaults
`timescale 1ns / 1ps

module swizzled_block_address_generator_unit import sbag_pkg::*; #(
   parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
   parameter int MAX_MEGA_DIM = MAX_MEGA_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   sbag_req_if.sink               req_ch,
   sbag_rsp_if.source             rsp_ch
);

   localparam int OFF_W = (OFFSET_BITS < SEL_FIELDS) ? OFFSET_BITS : SEL_FIELDS;
   localparam int DIM_W = $clog2(MAX_MEGA_DIM + 1);
   localparam int CMP_W = (DIM_W > MEGA_DIM_W) ? DIM_W : MEGA_DIM_W;
   localparam int RM_W  = MEGA_POS_W + DIM_W;
   localparam int MWB_W = DIM_W + STRIDE_W;
   localparam int MBL_W = MWB_W - 3;

   // configuration registers
   logic [SEL_W-1:0]      x_sel_ff, y_sel_ff;
   logic [MEGA_DIM_W-1:0] mega_width_ff, mega_height_ff;
   logic [STRIDE_W-1:0]   block_str_ff;
   logic [LINE_W-1:0]     line_str_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_sel_ff       <= '0;
         y_sel_ff       <= '0;
         mega_width_ff  <= MEGA_DIM_RST;
         mega_height_ff <= MEGA_DIM_RST;
         block_str_ff   <= STRIDE_RST;
         line_str_ff    <= LINE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_SEL:       x_sel_ff       <= csr_wdata[SEL_W-1:0];
            CSR_Y_SEL:       y_sel_ff       <= csr_wdata[SEL_W-1:0];
            CSR_MEGA_WIDTH:  mega_width_ff  <= csr_wdata[MEGA_DIM_W-1:0];
            CSR_MEGA_HEIGHT: mega_height_ff <= csr_wdata[MEGA_DIM_W-1:0];
            CSR_BLOCK_STR:   block_str_ff   <= csr_wdata[STRIDE_W-1:0];
            CSR_LINE_STR:    line_str_ff    <= csr_wdata[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [MEGA_DIM_W-1:0] d);
      logic [CMP_W-1:0] e;
      logic [CMP_W-1:0] c;
      e = CMP_W'(d);
      if (e == '0) begin
         c = CMP_W'(1);
      end else if (e > CMP_W'(MAX_MEGA_DIM)) begin
         c = CMP_W'(MAX_MEGA_DIM);
      end else begin
         c = e;
      end
      return DIM_W'(c);
   endfunction

   // stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ch.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: gather offset bits, clamp mega dimensions
   logic [FUNC_W-1:0]     s1_func_ff;
   logic [MEGA_POS_W-1:0] s1_col_ff, s1_row_ff;
   logic [INNER_W-1:0]    s1_ix_ff, s1_iy_ff;
   logic [OFF_W-1:0]      s1_off_ff, s1_off_in;
   logic [DIM_W-1:0]      s1_mw_ff, s1_mh_ff;

   assign s1_off_in = OFF_W'(gather_bits(x_sel_ff, req_ch.inner_x)
                             ^ gather_bits(y_sel_ff, req_ch.inner_y));

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_func_ff <= req_ch.func;
         s1_col_ff  <= req_ch.mega_col;
         s1_row_ff  <= req_ch.mega_row;
         s1_ix_ff   <= req_ch.inner_x;
         s1_iy_ff   <= req_ch.inner_y;
         s1_off_ff  <= s1_off_in;
         s1_mw_ff   <= clamp_dim(mega_width_ff);
         s1_mh_ff   <= clamp_dim(mega_height_ff);
      end
   end

   // tile column is offset mod width, tile row is offset div width
   logic [OFF_W-1:0] tile_row;
   logic [DIM_W-1:0] tile_col;

   sbag_divider #(
      .OFF_W (OFF_W),
      .DIM_W (DIM_W)
   ) u_divider (
      .clock     (clock),
      .stage_en  ({en3, en2}),
      .dividend  (s1_off_ff),
      .divisor   (s1_mw_ff),
      .quotient  (tile_row),
      .remainder (tile_col)
   );

   // stage 2: first products
   logic [FUNC_W-1:0]  s2_func_ff;
   logic               s2_bypass_ff;
   logic [INNER_W-1:0] s2_ix_ff, s2_iy_ff;
   logic [RM_W-1:0]    s2_rowmh_ff, s2_colmw_ff, s2_colmh_ff;
   logic [MWB_W-1:0]   s2_mwbs_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_func_ff   <= s1_func_ff;
         s2_bypass_ff <= (s1_mw_ff == DIM_W'(1)) && (s1_mh_ff == DIM_W'(1));
         s2_ix_ff     <= s1_ix_ff;
         s2_iy_ff     <= s1_iy_ff;
         s2_rowmh_ff  <= RM_W'(s1_row_ff) * RM_W'(s1_mh_ff);
         s2_colmw_ff  <= RM_W'(s1_col_ff) * RM_W'(s1_mw_ff);
         s2_colmh_ff  <= RM_W'(s1_col_ff) * RM_W'(s1_mh_ff);
         s2_mwbs_ff   <= MWB_W'(s1_mw_ff) * MWB_W'(block_str_ff);
      end
   end

   // stage 3: line terms and mega block terms
   logic [MBL_W-1:0]                s2_mbl;
   logic [RM_W:0]                   s2_lin_row, s2_lin_col;
   logic [RM_W+LINE_W:0]            s2_lin_a;
   logic [RM_W+STRIDE_W:0]          s2_lin_b;
   logic [RM_W+LINE_W-1:0]          s2_rowmhls;
   logic [RM_W+MBL_W-1:0]           s2_colmhmbl;

   assign s2_mbl      = s2_mwbs_ff[MWB_W-1:3];
   assign s2_lin_row  = (RM_W+1)'(s2_rowmh_ff) + (RM_W+1)'(s2_iy_ff);
   assign s2_lin_col  = (RM_W+1)'(s2_colmw_ff) + (RM_W+1)'(s2_ix_ff);
   assign s2_lin_a    = (RM_W+LINE_W+1)'(s2_lin_row) * (RM_W+LINE_W+1)'(line_str_ff);
   assign s2_lin_b    = (RM_W+STRIDE_W+1)'(s2_lin_col) * (RM_W+STRIDE_W+1)'(block_str_ff);
   assign s2_rowmhls  = (RM_W+LINE_W)'(s2_rowmh_ff) * (RM_W+LINE_W)'(line_str_ff);
   assign s2_colmhmbl = (RM_W+MBL_W)'(s2_colmh_ff) * (RM_W+MBL_W)'(s2_mbl);

   logic [FUNC_W-1:0] s3_func_ff;
   logic              s3_bypass_ff, s3_serr_ff;
   logic [MBL_W-1:0]  s3_mbl_ff;
   logic [ADDR_W-1:0] s3_lin_a_ff, s3_lin_b_ff, s3_rowmhls_ff, s3_colmhmbl_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_func_ff     <= s2_func_ff;
         s3_bypass_ff   <= s2_bypass_ff;
         s3_serr_ff     <= s2_mwbs_ff[2:0] != 3'b000;
         s3_mbl_ff      <= s2_mbl;
         s3_lin_a_ff    <= ADDR_W'(s2_lin_a);
         s3_lin_b_ff    <= ADDR_W'(s2_lin_b);
         s3_rowmhls_ff  <= ADDR_W'(s2_rowmhls);
         s3_colmhmbl_ff <= ADDR_W'(s2_colmhmbl);
      end
   end

   // stage 4: linear offset, tile terms of the blocked offset
   logic [OFF_W+MBL_W-1:0]    s3_rowmbl;
   logic [DIM_W+STRIDE_W-1:0] s3_colbs;

   assign s3_rowmbl = (OFF_W+MBL_W)'(tile_row) * (OFF_W+MBL_W)'(s3_mbl_ff);
   assign s3_colbs  = (DIM_W+STRIDE_W)'(tile_col) * (DIM_W+STRIDE_W)'(block_str_ff);

   logic [FUNC_W-1:0] s4_func_ff;
   logic              s4_bypass_ff, s4_serr_ff;
   logic [ADDR_W-1:0] s4_lin_ff, s4_bsum_ff, s4_rowmbl_ff, s4_colbs_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_func_ff   <= s3_func_ff;
         s4_bypass_ff <= s3_bypass_ff;
         s4_serr_ff   <= s3_serr_ff;
         s4_lin_ff    <= (s3_lin_a_ff << 3) + s3_lin_b_ff;
         s4_bsum_ff   <= s3_rowmhls_ff + s3_colmhmbl_ff;
         s4_rowmbl_ff <= ADDR_W'(s3_rowmbl);
         s4_colbs_ff  <= ADDR_W'(s3_colbs);
      end
   end

   // stage 5: blocked offset and source/destination select
   logic [ADDR_W-1:0] s4_blk;
   logic [ADDR_W-1:0] s5_src_ff, s5_dst_ff, s5_src_in, s5_dst_in;
   logic              s5_bypass_ff, s5_serr_ff;

   assign s4_blk = ((s4_bsum_ff + s4_rowmbl_ff) << 3) + s4_colbs_ff;

   always_comb begin
      if (s4_bypass_ff) begin
         s5_src_in = s4_lin_ff;
         s5_dst_in = s4_lin_ff;
      end else if (s4_func_ff == FUNC_LIN_TO_BLK) begin
         s5_src_in = s4_lin_ff;
         s5_dst_in = s4_blk;
      end else begin
         s5_src_in = s4_blk;
         s5_dst_in = s4_lin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_src_ff    <= s5_src_in;
         s5_dst_ff    <= s5_dst_in;
         s5_bypass_ff <= s4_bypass_ff;
         s5_serr_ff   <= s4_serr_ff;
      end
   end

   assign rsp_ch.valid        = v5_ff;
   assign rsp_ch.src_addr     = s5_src_ff;
   assign rsp_ch.dst_addr     = s5_dst_ff;
   assign rsp_ch.bypass       = s5_bypass_ff;
   assign rsp_ch.stride_error = s5_serr_ff;

endmodule

### hdl/sbag_divider.sv
// two stage pipelined restoring divider for tile column and row
`timescale 1ns / 1ps

module sbag_divider import sbag_pkg::*; #(
   parameter int OFF_W = SEL_FIELDS,
   parameter int DIM_W = $clog2(MAX_MEGA_DIM_DEF + 1)
) (
   input  logic             clock,
   input  logic [1:0]       stage_en,
   input  logic [OFF_W-1:0] dividend,
   input  logic [DIM_W-1:0] divisor,
   output logic [OFF_W-1:0] quotient,
   output logic [DIM_W-1:0] remainder
);

   localparam int STEPS_A = (OFF_W + 1) / 2;
   localparam int LO_A    = OFF_W - STEPS_A;

   logic [OFF_W-1:0] a_q_ff, a_q_in;
   logic [DIM_W-1:0] a_r_ff, a_r_in;
   logic [OFF_W-1:0] a_num_ff;
   logic [DIM_W-1:0] a_den_ff;
   logic [OFF_W-1:0] b_q_ff, b_q_in;
   logic [DIM_W-1:0] b_r_ff, b_r_in;

   // upper quotient bits
   always_comb begin
      logic [DIM_W:0]   t;
      logic [DIM_W-1:0] r;
      logic [OFF_W-1:0] q;
      r = '0;
      q = '0;
      for (int i = OFF_W - 1; i >= LO_A; i--) begin
         t = {r, dividend[i]};
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
            q[i] = 1'b1;
         end
         r = t[DIM_W-1:0];
      end
      a_q_in = q;
      a_r_in = r;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_q_ff   <= a_q_in;
         a_r_ff   <= a_r_in;
         a_num_ff <= dividend;
         a_den_ff <= divisor;
      end
   end

   // lower quotient bits
   always_comb begin
      logic [DIM_W:0]   t;
      logic [DIM_W-1:0] r;
      logic [OFF_W-1:0] q;
      r = a_r_ff;
      q = a_q_ff;
      for (int i = LO_A - 1; i >= 0; i--) begin
         t = {r, a_num_ff[i]};
         if (t >= {1'b0, a_den_ff}) begin
            t = t - {1'b0, a_den_ff};
            q[i] = 1'b1;
         end
         r = t[DIM_W-1:0];
      end
      b_q_in = q;
      b_r_in = r;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         b_q_ff <= b_q_in;
         b_r_ff <= b_r_in;
      end
   end

   assign quotient  = b_q_ff;
   assign remainder = b_r_ff;

endmodule
